@@ hdl/bkc_pkg.sv @@
// Shared types and constants for the keyframe curve block.
package bkc_pkg;

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W = 2;
  localparam int CNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_SET_LEFT  = 3'd1,
    CMD_SET_RIGHT = 3'd2,
    CMD_DEL_LEFT  = 3'd3,
    CMD_DEL_RIGHT = 3'd4,
    CMD_EVAL      = 3'd5,
    CMD_RSVD6     = 3'd6,
    CMD_RSVD7     = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DIV, S_WT1, S_WT2, S_WT3, S_MUL, S_SUM, S_DONE
  } state_t;

  // one anchor as held in a cell
  typedef struct packed {
    logic [VAL_W-1:0] tm;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] loff;
    logic [VAL_W-1:0] roff;
    logic             lp;
    logic             rp;
  } anchor_t;

  // command broadcast to all cells of the row
  typedef struct packed {
    logic             ins;
    logic             set_l;
    logic             set_r;
    logic             del_l;
    logic             del_r;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] off;
  } cell_ctl_t;

endpackage

@@ hdl/bkc_cell.sv @@
// One anchor slot of the sorted table; shifts toward higher slots on insert.
module bkc_cell
  import bkc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      used,      // slot holds an anchor
  input  logic      prev_gt,   // lower neighbor is used and later than key
  input  anchor_t   prev_a,
  output logic      gt,        // this slot is used and later than key
  output logic      hit,       // this slot holds the key
  output anchor_t   a
);

  logic hold_gt;

  assign hold_gt = used && (a.tm > ctl.key);
  assign gt = hold_gt;
  assign hit = used && (a.tm == ctl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      a.tm <= '0;
      a.lp <= 1'b0;
      a.rp <= 1'b0;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        a <= prev_a;
      end else if (hold_gt || !used) begin
        // take the new anchor if this is its slot
        if (hold_gt || !used) begin
          a.tm   <= ctl.key;
          a.val  <= ctl.val;
          a.loff <= '0;
          a.roff <= '0;
          a.lp   <= 1'b0;
          a.rp   <= 1'b0;
        end
      end
    end else if (hit) begin
      if (ctl.set_l) begin
        a.loff <= ctl.off;
        a.lp   <= 1'b1;
      end
      if (ctl.set_r) begin
        a.roff <= ctl.off;
        a.rp   <= 1'b1;
      end
      if (ctl.del_l) a.lp <= 1'b0;
      if (ctl.del_r) a.rp <= 1'b0;
    end
  end

endmodule

@@ hdl/bkc_div.sv @@
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit a cycle.
module bkc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] quo
);

  logic [47:0] q;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[47]} - {1'b0, den};
  assign quo = q[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[47]};
          q   <= {q[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/bezier_keyframe_curve.sv @@
// Keyframe curve top level: cell row, scanner, divider and Bernstein blend.
// Table commands: the scan state compares and updates, then the done state loads the result;
// a new request is taken only once the previous result has been accepted.
// Evaluate: the scan walks the anchors one by one, then a 48-step divider, three
// weight states and four multiply-accumulate steps form the blend.
// One request at a time. Synchronous reset empties the table to the anchor
// at time zero, clears start_value and all handle flags.
module bezier_keyframe_curve
  import bkc_pkg::*;
#(
  parameter int MAX_ANCHORS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [103:0] s_tdata,  // cmd[2:0] time_key[34:3] anchor_value[66:35]
                                 // handle_offset[98:67], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_value[31:0] status[33:32]
                                 // anchor_count[38:34], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int NW = $clog2(MAX_ANCHORS + 1);

  state_t state, state_next;
  logic [31:0] start_value;
  cmd_t  cmd;
  logic [31:0] key, aval, hoff;
  logic [NW-1:0] used_n;
  cell_ctl_t ctl;
  anchor_t cells [MAX_ANCHORS];
  logic [MAX_ANCHORS-1:0] gtv, hitv;
  logic [IW-1:0] idx;
  anchor_t sa, ea;
  logic [31:0] v0, v1;
  logic [16:0] tq;
  logic [16:0] uq;
  logic div_start, div_done;
  logic [16:0] div_q;
  logic [33:0] tu;      // t*u
  logic [33:0] tt, uu;
  logic [48:0] w0, w1, w2, w3;
  logic signed [33:0] p0, p1, p2, p3;
  logic [1:0] mk;
  logic signed [33:0] psel;
  logic [48:0] wsel;
  logic signed [59:0] mh;
  logic signed [58:0] ml;
  logic signed [86:0] acc;
  logic signed [38:0] rnd;
  logic [31:0] res;
  status_t st;
  logic lin_end;
  logic [1:0] ph;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) start_value <= '0;
    else if (cfg_valid) start_value <= cfg_data;
  end

  // cell row
  genvar g;
  generate
    for (g = 0; g < MAX_ANCHORS; g++) begin : gen_cell
      logic pg;
      anchor_t pa;
      if (g == 0) begin : g_first
        assign pg = 1'b0;
        assign pa = cells[0];
      end else begin : g_rest
        assign pg = gtv[g-1];
        assign pa = cells[g-1];
      end
      bkc_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .used(NW'(g) < used_n), .prev_gt(pg), .prev_a(pa),
        .gt(gtv[g]), .hit(hitv[g]), .a(cells[g])
      );
    end
  endgenerate

  // request register and command decode
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd  <= cmd_t'(s_tdata[2:0]);
      key  <= s_tdata[34:3];
      aval <= s_tdata[66:35];
      hoff <= s_tdata[98:67];
    end
  end

  logic any_hit;
  assign any_hit = |hitv;

  always_comb begin
    ctl = '0;
    ctl.key = key;
    ctl.val = aval;
    ctl.off = hoff;
    if (state == S_SCAN && ph == 2'd0) begin
      case (cmd)
        CMD_INSERT: ctl.ins = !any_hit && (used_n < NW'(MAX_ANCHORS));
        CMD_SET_LEFT: ctl.set_l = 1'b1;
        CMD_SET_RIGHT: ctl.set_r = 1'b1;
        CMD_DEL_LEFT: ctl.del_l = 1'b1;
        CMD_DEL_RIGHT: ctl.del_r = 1'b1;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid && s_tready) state_next = S_SCAN;
      S_SCAN: begin
        if (cmd != CMD_EVAL) state_next = S_DONE;
        else if (ph == 2'd1 && (gtv[idx] || idx == IW'(used_n - NW'(1))))
          state_next = lin_end ? S_DONE : S_DIV;
      end
      S_DIV: if (div_done) state_next = S_WT1;
      S_WT1: state_next = S_WT2;
      S_WT2: state_next = S_WT3;
      S_WT3: state_next = S_MUL;
      S_MUL: if (mk == 2'd3) state_next = S_SUM;
      S_SUM: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // scan walks idx up the row until a later anchor or the last one
  assign lin_end = !gtv[idx] || (idx == '0);
  assign div_start = (state == S_SCAN) && (state_next == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      used_n <= NW'(1);
      ph <= 2'd0;
    end else begin
      if (ctl.ins) used_n <= used_n + NW'(1);
      if (state == S_IDLE) begin
        ph  <= 2'd0;
        idx <= '0;
      end else if (state == S_SCAN) begin
        if (ph == 2'd0) begin
          ph <= 2'd1;
          if (cmd == CMD_INSERT)
            st <= any_hit ? ST_PRESENT :
                  (used_n >= NW'(MAX_ANCHORS)) ? ST_FULL : ST_OK;
          else if (cmd inside {[CMD_SET_LEFT:CMD_DEL_RIGHT]})
            st <= any_hit ? ST_OK : ST_ABSENT;
          else
            st <= ST_OK;
        end else if (state_next == S_SCAN) begin
          idx <= idx + IW'(1);
        end
      end
    end
  end

  // segment endpoints, registered when scan ends
  always_ff @(posedge clk) begin
    if (state == S_SCAN && ph == 2'd1) begin
      ea <= cells[idx];
      sa <= cells[(idx == '0) ? idx : idx - IW'(1)];
      v1 <= (idx == '0) ? start_value : cells[idx].val;
      v0 <= (idx <= IW'(1)) ? start_value : cells[idx - IW'(1)].val;
      if (lin_end) res <= (idx == '0) ? start_value : cells[idx].val;
    end
    if (state == S_SUM) res <= (rnd > 39'sd2147483647) ? 32'h7fffffff :
                               (rnd < -39'sd2147483648) ? 32'h80000000 : rnd[31:0];
  end

  // dividend is taken at start, before the endpoint registers load
  bkc_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({key - cells[idx - IW'(1)].tm, 16'd0}), .den(ea.tm - sa.tm),
    .done(div_done), .quo(div_q)
  );

  // one control point per step, weight split into high and low parts
  always_comb begin
    case (mk)
      2'd0: begin
        psel = p0;
        wsel = w0;
      end
      2'd1: begin
        psel = p1;
        wsel = w1;
      end
      2'd2: begin
        psel = p2;
        wsel = w2;
      end
      default: begin
        psel = p3;
        wsel = w3;
      end
    endcase
  end

  assign mh = psel * signed'({1'b0, wsel[48:24]});
  assign ml = psel * signed'({1'b0, wsel[23:0]});

  // weights from the registered multiply steps in S_WT1 and S_WT2
  always_ff @(posedge clk) begin
    case (state)
      S_DIV: if (div_done) begin
        tq <= div_q;
        uq <= 17'd65536 - div_q;
      end
      S_WT1: begin
        tt <= 34'(tq * tq);
        uu <= 34'(uq * uq);
        tu <= 34'(tq * uq);
        p0 <= 34'(signed'(v0));
        p3 <= 34'(signed'(v1));
        p1 <= sa.rp ? 34'(signed'(v0)) + 34'(signed'(sa.roff)) : '0;
        p2 <= ea.lp ? 34'(signed'(v1)) + 34'(signed'(ea.loff)) : '0;
      end
      S_WT2: begin
        if (sa.rp && ea.lp) begin
          w0 <= 49'(uu * uq);
          w1 <= 49'(3 * tu * uq);
          w2 <= 49'(3 * tu * tq);
          w3 <= 49'(tt * tq);
        end else if (sa.rp || ea.lp) begin
          w0 <= 49'({uu[33:0], 16'd0});
          w3 <= 49'({tt[33:0], 16'd0});
          w1 <= sa.rp ? 49'({tu, 17'd0}) : '0;
          w2 <= ea.lp ? 49'({tu, 17'd0}) : '0;
        end else begin
          w0 <= 49'({uq, 32'd0});
          w3 <= 49'({tq, 32'd0});
          w1 <= '0;
          w2 <= '0;
        end
      end
      S_WT3: begin
        // seed with the rounding half
        acc <= 87'sd1 <<< 47;
        mk  <= 2'd0;
      end
      S_MUL: begin
        acc <= acc + (87'(mh) <<< 24) + 87'(ml);
        mk  <= mk + 2'd1;
      end
      default: ;
    endcase
  end

  assign rnd = 39'(acc >>> 48);

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == S_DONE) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE)
      m_tdata <= {1'b0, 5'(used_n), st, (cmd == CMD_EVAL) ? res : 32'd0};
  end

endmodule
